/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the unaligned load/store merge block.
// Needs nothing else; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_IMP_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_IMP_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/ulsm_pkg.sv */
// Package for the unaligned load/store merge block: item types, op codes, keep-mask tables.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ulsm_pkg;

	typedef enum logic [2:0] {
		OP_LWL = 3'd0,
		OP_LWR = 3'd1,
		OP_LDL = 3'd2,
		OP_LDR = 3'd3,
		OP_SWL = 3'd4,
		OP_SWR = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [31:0]        base_value;
		logic signed [15:0] offset;
		logic [63:0]        old_reg_value;
		logic [63:0]        mem_data;
	} req_t;

	typedef struct packed {
		logic [31:0] access_addr;
		logic [63:0] reg_result;
		logic        reg_write;
		logic [31:0] store_data;
		logic        store_write;
	} rsp_t;

	function automatic logic [31:0] lwl_keep(input logic [1:0] k);
		logic [31:0] m;
		case (k)
			2'd0: m = 32'h0000_0000;
			2'd1: m = 32'h0000_00FF;
			2'd2: m = 32'h0000_FFFF;
			default: m = 32'h00FF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] lwr_keep(input logic [1:0] k);
		logic [31:0] m;
		case (k)
			2'd0: m = 32'hFFFF_FF00;
			2'd1: m = 32'hFFFF_0000;
			2'd2: m = 32'hFF00_0000;
			default: m = 32'h0000_0000;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] swl_keep(input logic [1:0] k);
		logic [31:0] m;
		case (k)
			2'd0: m = 32'h0000_0000;
			2'd1: m = 32'hFF00_0000;
			2'd2: m = 32'hFFFF_0000;
			default: m = 32'hFFFF_FF00;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] swr_keep(input logic [1:0] k);
		logic [31:0] m;
		case (k)
			2'd0: m = 32'h00FF_FFFF;
			2'd1: m = 32'h0000_FFFF;
			2'd2: m = 32'h0000_00FF;
			default: m = 32'h0000_0000;
		endcase
		return m;
	endfunction

	function automatic logic [63:0] ldl_keep(input logic [2:0] k);
		logic [63:0] m;
		case (k)
			3'd0: m = 64'h0000_0000_0000_0000;
			3'd1: m = 64'h0000_0000_0000_00FF;
			3'd2: m = 64'h0000_0000_0000_FFFF;
			3'd3: m = 64'h0000_0000_00FF_FFFF;
			3'd4: m = 64'h0000_0000_FFFF_FFFF;
			3'd5: m = 64'h0000_00FF_FFFF_FFFF;
			3'd6: m = 64'h0000_FFFF_FFFF_FFFF;
			default: m = 64'h00FF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [63:0] ldr_keep(input logic [2:0] k);
		logic [63:0] m;
		case (k)
			3'd0: m = 64'hFFFF_FFFF_FFFF_FF00;
			3'd1: m = 64'hFFFF_FFFF_FFFF_0000;
			3'd2: m = 64'hFFFF_FFFF_FF00_0000;
			3'd3: m = 64'hFFFF_FFFF_0000_0000;
			3'd4: m = 64'hFFFF_FF00_0000_0000;
			3'd5: m = 64'hFFFF_0000_0000_0000;
			3'd6: m = 64'hFF00_0000_0000_0000;
			default: m = 64'h0000_0000_0000_0000;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/unaligned_load_store_merge.sv */
// Top level of the unaligned load/store merge block: three-stage merge pipeline.
// Depends on ulsm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Byte-merge datapath for LWL, LWR, LDL, LDR, SWL and SWR.
// Request channel (req_valid/req_ready/req) carries one item: the operation, base
// register, signed displacement, old target register value and the aligned memory
// data already fetched. Response channel (rsp_valid/rsp_ready/rsp) returns one item
// per request: the aligned access address and either the merged register value
// (reg_write set) or the merged store word (store_write set). Codes 6 and 7 return
// only the word-aligned address with every other field zero.
// A request accepted into stage 1 is registered in stage 2 and then in the output
// register, from which it is presented on rsp.
// Throughput: one item per cycle while rsp_ready stays high, set by the three register
// stages each taking a new item whenever the stage after it moves on or is empty.
// Stage 1 forms the effective address, stage 2 does the byte shift and
// keep mask, stage 3 (the output register) merges and sign-extends.
// When the receiver stalls, the output register holds its item and the stalls
// ripple back a stage at a time; earlier stages fill their empty slots first,
// so req_ready drops only once all three stages hold items.
// Reset clears every stage's valid bit; payload registers are not reset.
module unaligned_load_store_merge
	import ulsm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	// Stage valid bits and the advance conditions between stages.
	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	// Stage 1 payload: operation, effective address, the two data words.
	op_t         op_s1;
	logic [31:0] addr_s1;
	logic [63:0] old_s1;
	logic [63:0] mem_s1;

	// Stage 2 payload: shifted data and kept bytes, ready to be ORed.
	op_t         op_s2;
	logic [31:0] acc_s2;
	logic [63:0] sh_s2;
	logic [63:0] keep_s2;

	// Stage 3 payload is the response item itself.
	rsp_t        rsp_s3;

	// Stage 2 combinational results.
	logic [1:0]  w_c;
	logic [2:0]  d_c;
	logic [31:0] mem32_c;
	logic [31:0] old32_c;
	logic [31:0] acc_c;
	logic [63:0] sh_c;
	logic [63:0] keep_c;

	// Stage 3 combinational results.
	logic [63:0] merged_c;
	rsp_t        rsp_c;

	// A stage takes a new item when it is empty or its item moves on.
	assign adv_s3    = !v_s3 || rsp_ready;
	assign adv_s2    = !v_s2 || adv_s3;
	assign adv_s1    = !v_s1 || adv_s2;
	assign req_ready = adv_s1;

	assign rsp_valid = v_s3;
	assign rsp       = rsp_s3;

	// Valid bits: each stage loads the valid of the stage before when it advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= req_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage 1: capture the item and form base + sign-extended displacement,
	// wrapping modulo 2^32.
	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			op_s1   <= op_t'(req.req_type);
			addr_s1 <= req.base_value + {{16{req.offset[15]}}, req.offset};
			old_s1  <= req.old_reg_value;
			mem_s1  <= req.mem_data;
		end
	end

	// Stage 2: pick the aligned address, the shifted source and the kept bytes
	// by the low address bits.
	always_comb begin
		w_c     = addr_s1[1:0];
		d_c     = addr_s1[2:0];
		mem32_c = mem_s1[31:0];
		old32_c = old_s1[31:0];
		acc_c   = {addr_s1[31:2], 2'b00};
		sh_c    = '0;
		keep_c  = '0;
		unique case (op_s1) inside
			OP_LWL: begin
				sh_c   = {32'd0, mem32_c << {w_c, 3'b000}};
				keep_c = {32'd0, old32_c & lwl_keep(w_c)};
			end
			OP_LWR: begin
				sh_c   = {32'd0, mem32_c >> (5'd24 - {w_c, 3'b000})};
				keep_c = {32'd0, old32_c & lwr_keep(w_c)};
			end
			OP_LDL: begin
				acc_c  = {addr_s1[31:3], 3'b000};
				sh_c   = mem_s1 << {d_c, 3'b000};
				keep_c = old_s1 & ldl_keep(d_c);
			end
			OP_LDR: begin
				acc_c  = {addr_s1[31:3], 3'b000};
				sh_c   = mem_s1 >> (6'd56 - {d_c, 3'b000});
				keep_c = old_s1 & ldr_keep(d_c);
			end
			OP_SWL: begin
				// Store source is the low word of the register only.
				sh_c   = {32'd0, old32_c >> {w_c, 3'b000}};
				keep_c = {32'd0, mem32_c & swl_keep(w_c)};
			end
			OP_SWR: begin
				sh_c   = {32'd0, old32_c << (5'd24 - {w_c, 3'b000})};
				keep_c = {32'd0, mem32_c & swr_keep(w_c)};
			end
			default: begin
				// Unused codes: word-aligned address, nothing else.
				sh_c   = '0;
				keep_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			op_s2   <= op_s1;
			acc_s2  <= acc_c;
			sh_s2   <= sh_c;
			keep_s2 <= keep_c;
		end
	end

	// Stage 3: merge, sign-extend the word loads, steer to register or memory.
	always_comb begin
		merged_c          = sh_s2 | keep_s2;
		rsp_c.access_addr = acc_s2;
		rsp_c.reg_result  = '0;
		rsp_c.reg_write   = 1'b0;
		rsp_c.store_data  = '0;
		rsp_c.store_write = 1'b0;
		unique case (op_s2) inside
			OP_LWL, OP_LWR: begin
				rsp_c.reg_result = {{32{merged_c[31]}}, merged_c[31:0]};
				rsp_c.reg_write  = 1'b1;
			end
			OP_LDL, OP_LDR: begin
				rsp_c.reg_result = merged_c;
				rsp_c.reg_write  = 1'b1;
			end
			OP_SWL, OP_SWR: begin
				rsp_c.store_data  = merged_c[31:0];
				rsp_c.store_write = 1'b1;
			end
			default: begin
				rsp_c.reg_write = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			rsp_s3 <= rsp_c;
		end
	end

	// A held stage keeps its item until the next stage takes it.
	`ASSERT_IMP_NEXT(a_s1_hold, clk, arst_n, v_s1 && !adv_s2, v_s1)
	`ASSERT_IMP_NEXT(a_s2_hold, clk, arst_n, v_s2 && !adv_s3, v_s2)
	// A response never asks for both a register write and a memory write.
	`ASSERT_IMP(a_one_target, clk, arst_n, rsp_valid, !(rsp.reg_write && rsp.store_write))
	// Every access address is at least word aligned.
	`ASSERT_IMP(a_addr_align, clk, arst_n, rsp_valid, rsp.access_addr[1:0] == 2'b00)

endmodule

`default_nettype wire

/* tb/ulsm_checker.sv */
// Scoreboard for the unaligned load/store merge block: watches both channels,
// predicts each merge and compares field by field. Depends on ulsm_pkg.
`timescale 1ns / 1ps

module ulsm_checker
	import ulsm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending,
	output int   results_checked
);

	rsp_t expected_merges[$];

	// Predict one merge: effective address, alignment, keep mask and shift.
	function automatic rsp_t merge_bytes(input req_t r);
		logic [31:0] ea;
		logic [31:0] mem32;
		logic [31:0] old32;
		logic [31:0] word;
		logic [63:0] ones64;
		int          wsh;
		int          dsh;
		rsp_t        p;
		ea     = r.base_value + {{16{r.offset[15]}}, r.offset};
		mem32  = r.mem_data[31:0];
		old32  = r.old_reg_value[31:0];
		ones64 = '1;
		wsh    = 8 * int'(ea[1:0]);
		dsh    = 8 * int'(ea[2:0]);
		p      = '0;
		p.access_addr = {ea[31:2], 2'b00};
		case (r.req_type)
			OP_LWL: begin
				word = (old32 & ~(32'hFFFF_FFFF << wsh)) | (mem32 << wsh);
				p.reg_result = {{32{word[31]}}, word};
				p.reg_write  = 1'b1;
			end
			OP_LWR: begin
				word = (old32 & (32'hFFFF_FFFF << (wsh + 8))) | (mem32 >> (24 - wsh));
				p.reg_result = {{32{word[31]}}, word};
				p.reg_write  = 1'b1;
			end
			OP_LDL: begin
				p.access_addr = {ea[31:3], 3'b000};
				p.reg_result  = (r.old_reg_value & ~(ones64 << dsh)) | (r.mem_data << dsh);
				p.reg_write   = 1'b1;
			end
			OP_LDR: begin
				p.access_addr = {ea[31:3], 3'b000};
				p.reg_result  = (r.old_reg_value & (ones64 << (dsh + 8)))
					| (r.mem_data >> (56 - dsh));
				p.reg_write   = 1'b1;
			end
			OP_SWL: begin
				// stores take only the low word of the source register
				p.store_data  = (mem32 & ~(32'hFFFF_FFFF >> wsh)) | (old32 >> wsh);
				p.store_write = 1'b1;
			end
			OP_SWR: begin
				p.store_data  = (mem32 & (32'hFFFF_FFFF >> (wsh + 8))) | (old32 << (24 - wsh));
				p.store_write = 1'b1;
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		fail_count = fail_count + 1;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want)
			flag_mismatch($sformatf("result %0d, %s: got %h, want %h",
				results_checked, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			expected_merges.delete();
			fail_count      = 0;
			results_checked = 0;
			pending        <= 0;
		end else begin
			if (req_valid && req_ready)
				expected_merges.push_back(merge_bytes(req));
			if (rsp_valid && rsp_ready) begin
				if (expected_merges.size() == 0) begin
					flag_mismatch("result with no item outstanding");
				end else begin
					want = expected_merges.pop_front();
					check_field("access_addr", 64'(rsp.access_addr), 64'(want.access_addr));
					check_field("reg_result", rsp.reg_result, want.reg_result);
					check_field("reg_write", 64'(rsp.reg_write), 64'(want.reg_write));
					check_field("store_data", 64'(rsp.store_data), 64'(want.store_data));
					check_field("store_write", 64'(rsp.store_write), 64'(want.store_write));
				end
				results_checked = results_checked + 1;
			end
			pending <= expected_merges.size();
		end
	end

endmodule

/* tb/tb_unaligned_load_store_merge.sv */
// Top of the unaligned load/store merge testbench: clock, reset, stimulus and verdict.
// Depends on ulsm_pkg, ulsm_checker and the block itself.
`timescale 1ns / 1ps

module tb_unaligned_load_store_merge;
	import ulsm_pkg::*;

	localparam int RESET_CYCLES = 6;
	localparam int PHASE_ITEMS  = 275;     // four random phases, about 1100 items
	localparam int FILL_ITEMS   = 40;      // offered back to back during the long hold
	localparam int LONG_HOLD    = 150;     // receiver hold-off, in cycles
	localparam int TAIL_CYCLES  = 12;      // pipeline is three deep; wait a few more
	localparam int CYCLE_LIMIT  = 500000;

	// the two codes with no operation behind them
	localparam logic [2:0] OP_SPARE0 = 3'd6;
	localparam logic [2:0] OP_SPARE1 = 3'd7;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req_item;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp_item;

	int fail_count;
	int pending;
	int results_checked;

	int cycles;
	int ready_pct;       // chance per cycle that the receiver takes a result
	bit gapless;         // when set, the sender offers items with no idle cycles
	bit hold_rsp_req;    // ask the receiver for one long hold-off
	int sent_loads;
	int sent_stores;
	int sent_spare;

	unaligned_load_store_merge u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp_item)
	);

	ulsm_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req             (req_item),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.rsp             (rsp_item),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Idle length between items: mostly none or short, now and then long.
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (gapless)
			return 0;
		if (pick < 50)
			return 0;
		if (pick < 80)
			return $urandom_range(1, 3);
		if (pick < 96)
			return $urandom_range(4, 12);
		return $urandom_range(25, 80);
	endfunction

	function automatic req_t mk_item(input logic [2:0] op, input logic [31:0] base,
		input logic [15:0] off, input logic [63:0] old, input logic [63:0] mem);
		req_t r;
		r.req_type      = op;
		r.base_value    = base;
		r.offset        = off;
		r.old_reg_value = old;
		r.mem_data      = mem;
		return r;
	endfunction

	// Random item: mostly real operations, a few spare codes, some extreme data.
	function automatic req_t random_item();
		req_t r;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 2)
			r.req_type = OP_SPARE0;
		else if (pick < 4)
			r.req_type = OP_SPARE1;
		else
			r.req_type = 3'($urandom_range(0, 5));
		r.base_value    = $urandom;
		r.offset        = 16'($urandom);
		r.old_reg_value = {$urandom, $urandom};
		r.mem_data      = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0: r.old_reg_value = '1;
			1: r.old_reg_value = '0;
			2: r.mem_data      = '1;
			3: r.mem_data      = '0;
			4: r.base_value    = '1;
			5: r.base_value    = '0;
			6: r.offset        = 16'h8000;
			7: r.offset        = 16'h7FFF;
			default: ;
		endcase
		return r;
	endfunction

	// Offer one item, hold it until taken, then idle for a while unless told not to.
	task automatic send_item(input req_t r, input bit no_idle);
		int gap;
		req_valid <= 1'b1;
		req_item  <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		case (r.req_type)
			OP_LWL, OP_LWR, OP_LDL, OP_LDR: sent_loads++;
			OP_SWL, OP_SWR: sent_stores++;
			default: sent_spare++;
		endcase
		gap = no_idle ? 0 : idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, then wait until every expected result has come back. The first
	// edge lets the scoreboard count an item accepted in the current step.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Receiver: random ready, the odd long gap, and one long hold-off on request.
	initial begin
		rsp_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_rsp_req) begin
				hold_rsp_req = 1'b0;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if ($urandom_range(0, 299) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else begin
				rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
				@(posedge clk);
			end
		end
	end

	// Sender and verdict.
	initial begin
		int phase;
		int n;
		int pct[4];
		pct       = '{100, 75, 35, 90};
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_item  = '0;
		ready_pct = 100;
		gapless   = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: alignment extremes for each operation, sign extension,
		// stores with a dirty upper source word, spare codes, address wrap.
		send_item(mk_item(OP_LWL, 32'h0000_0000, 16'h0000, '1, 64'h0000_0000_8000_0000), 0);
		send_item(mk_item(OP_LWL, 32'h0000_0003, 16'h0000, 64'h0123_4567_7FFF_FFFF,
			64'hDEAD_BEEF_1234_5678), 0);
		send_item(mk_item(OP_LWR, 32'h0000_1000, 16'h0000, 64'hFFFF_FFFF_0000_0000,
			64'h0000_0000_89AB_CDEF), 0);
		send_item(mk_item(OP_LWR, 32'h0000_1000, 16'h0003, 64'h0000_0000_FEDC_BA98,
			64'h0000_0000_7654_3210), 0);
		send_item(mk_item(OP_LDL, 32'h0000_2000, 16'h0000, '1, 64'h0102_0304_0506_0708), 0);
		send_item(mk_item(OP_LDL, 32'h0000_2000, 16'h0007, 64'h1111_2222_3333_4444,
			64'hAAAA_BBBB_CCCC_DDDD), 0);
		send_item(mk_item(OP_LDR, 32'h0000_3000, 16'h0000, 64'h1357_9BDF_2468_ACE0,
			64'hF0E1_D2C3_B4A5_9687), 0);
		send_item(mk_item(OP_LDR, 32'h0000_3000, 16'h0007, '1, 64'h0011_2233_4455_6677), 0);
		send_item(mk_item(OP_SWL, 32'h0000_4000, 16'h0000, 64'hFFFF_FFFF_1234_5678, '1), 0);
		send_item(mk_item(OP_SWL, 32'h0000_4000, 16'h0003, 64'hABCD_EF01_8765_4321,
			64'h0000_0000_CAFE_F00D), 0);
		send_item(mk_item(OP_SWR, 32'h0000_5000, 16'h0000, 64'h5555_5555_0BAD_CAFE, '1), 0);
		send_item(mk_item(OP_SWR, 32'h0000_5000, 16'h0003, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0000_0000_1234_5678), 0);
		send_item(mk_item(OP_SPARE0, 32'h0000_6007, 16'h0001, '1, '1), 0);
		send_item(mk_item(OP_SPARE1, 32'hFFFF_FFFF, 16'h7FFF, '1, '1), 0);
		send_item(mk_item(OP_LWL, 32'hFFFF_FFFF, 16'h0001, 64'h0000_0000_0000_00FF,
			64'h0000_0000_8765_4321), 0);
		send_item(mk_item(OP_LDR, 32'h0000_0000, 16'hFFFF, 64'h0123_4567_89AB_CDEF, '1), 0);
		send_item(mk_item(OP_LDL, 32'h7FFF_0000, 16'h7FFF, 64'hFEDC_BA98_7654_3210, '1), 0);
		send_item(mk_item(OP_SWR, 32'h0001_0000, 16'h8000, '1, 64'h0000_0000_A5A5_A5A5), 0);
		send_item(mk_item(OP_LWR, 32'h0000_0001, 16'h0000, '0, '1), 0);
		send_item(mk_item(OP_LDR, 32'h0000_0004, 16'h0000, '1, '0), 0);
		send_item(mk_item(OP_SWL, 32'h0000_0002, 16'h0000, '1, '0), 0);
		send_item(mk_item(OP_LWL, 32'h0000_0002, 16'h0000, '0, '1), 0);

		// Pause the sender until the directed results are all in.
		wait_drained();

		// Random phases at different receiver rates; idling toggles in bursts.
		for (phase = 0; phase < 4; phase++) begin
			ready_pct = pct[phase];
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 49) == 0)
					gapless = !gapless;
				if (phase == 1 && n == PHASE_ITEMS / 2) begin
					// Hold the receiver off and keep offering items back to
					// back, so the pipeline fills and drops req_ready.
					hold_rsp_req = 1'b1;
					repeat (FILL_ITEMS) send_item(random_item(), 1);
				end
				send_item(random_item(), 0);
			end
			wait_drained();
		end
		req_valid <= 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);

		$display("covered %0d loads, %0d stores and %0d spare codes; %0d results checked",
			sent_loads, sent_stores, sent_spare, results_checked);
		$display("receiver rates 100/75/35/90 percent, one %0d-cycle hold-off with a full pipe",
			LONG_HOLD);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
